/* hw/rtl/fgf_pkg.sv */
package fgf_pkg;

  localparam int unsigned SeqBitsDef    = 7;
  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned StampBits     = 32;
  localparam int unsigned DigBits       = 8;
  localparam int unsigned LostBits      = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_DIV,
    ST_FILL,
    ST_REAL
  } fgf_state_e;

endpackage

/* hw/rtl/frame_gap_filler_top.sv */
// Sequence gap filler for sensor frames. Each frame carries a sequence number,
// eight analog samples, a digital word and a wrapping microsecond stamp. A frame
// that matches the expected number, or the first one after reset or restart, is
// sent through unchanged. If 1 to 2^(SEQ_BITS-1)-1 numbers are missing, one
// filler per missing number goes out first, with the previous analog values and
// a stamp interpolated as prev + (new - prev) / r. Larger jumps resync without
// fillers. Each filler waits on the bit-serial 32-step divider behind the
// stamp interpolation. One frame is handled at a time; the output register
// lets the next frame be taken while the last result waits.
module frame_gap_filler_top #(
  parameter int unsigned SEQ_BITS    = fgf_pkg::SeqBitsDef,
  parameter int unsigned SAMPLE_BITS = fgf_pkg::SampleBitsDef,
  localparam int unsigned InW        = SEQ_BITS + 8 * SAMPLE_BITS + fgf_pkg::DigBits
                                       + fgf_pkg::StampBits,
  localparam int unsigned InTw       = ((InW + 7) / 8) * 8,
  localparam int unsigned OutTw      = ((InW + fgf_pkg::LostBits + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // seq_in, analog_low, analog_high, digital_in, stamp_in (lowest bit up)
  input  logic [InTw-1:0]     s_axis_tdata,
  // restart
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // seq_out, analog_low_out, analog_high_out, digital_out, stamp_out, lost_count
  output logic [OutTw-1:0]    m_axis_tdata,
  // filled
  output logic                m_axis_tuser,
  // last_of_run
  output logic                m_axis_tlast
);

  localparam int unsigned AW     = 4 * SAMPLE_BITS;
  localparam int unsigned SW     = fgf_pkg::StampBits;
  localparam int unsigned DW     = fgf_pkg::DigBits;
  localparam int unsigned LW     = fgf_pkg::LostBits;
  localparam int unsigned OffAlo = SEQ_BITS;
  localparam int unsigned OffAhi = OffAlo + AW;
  localparam int unsigned OffDig = OffAhi + AW;
  localparam int unsigned OffStm = OffDig + DW;
  localparam logic [SEQ_BITS-1:0] RLast = SEQ_BITS'(2);

  fgf_pkg::fgf_state_e state_q, state_d;

  // current frame
  logic [SEQ_BITS-1:0] cur_seq_q;
  logic [AW-1:0]       cur_alo_q, cur_ahi_q;
  logic [DW-1:0]       cur_dig_q;
  logic [SW-1:0]       cur_stamp_q;

  // tracking state
  logic                valid_q;
  logic [SEQ_BITS-1:0] exp_q;
  logic [AW-1:0]       prev_alo_q, prev_ahi_q;
  logic [DW-1:0]       prev_dig_q;
  logic [SW-1:0]       prev_stamp_q;
  logic [LW-1:0]       lost_q;
  logic [SEQ_BITS-1:0] r_q;

  // output register
  logic                out_valid_q;
  logic [SEQ_BITS-1:0] out_seq_q;
  logic [AW-1:0]       out_alo_q, out_ahi_q;
  logic [DW-1:0]       out_dig_q;
  logic [SW-1:0]       out_stamp_q;
  logic                out_filled_q, out_last_q;
  logic [LW-1:0]       out_lost_q;

  logic                in_xact, can_load, gap, last_fill;
  logic                load_fill, load_real, div_start, div_done;
  logic [SEQ_BITS-1:0] seq_dist;
  logic [SW-1:0]       div_quo, fill_stamp;
  logic [DW-1:0]       fill_dig;
  logic [LW-1:0]       lost_inc;

  assign in_xact    = s_axis_tvalid && s_axis_tready;
  assign can_load   = !out_valid_q || m_axis_tready;
  assign seq_dist   = cur_seq_q - exp_q;
  // a gap below half the sequence space is filled, anything larger resyncs
  assign gap        = valid_q && (seq_dist != '0) && !seq_dist[SEQ_BITS-1];
  assign last_fill  = r_q == RLast;
  assign fill_stamp = prev_stamp_q + div_quo;
  assign fill_dig   = (r_q > RLast) ? prev_dig_q : cur_dig_q;
  assign lost_inc   = (&lost_q) ? lost_q : lost_q + 1'b1;

  fgf_div #(
    .SEQ_BITS (SEQ_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_stamp_q - prev_stamp_q),
    .divisor_i  (r_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fgf_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = fgf_pkg::ST_CHECK;
      fgf_pkg::ST_CHECK: state_d = gap ? fgf_pkg::ST_START : fgf_pkg::ST_REAL;
      fgf_pkg::ST_START: state_d = fgf_pkg::ST_DIV;
      fgf_pkg::ST_DIV:   if (div_done) state_d = fgf_pkg::ST_FILL;
      fgf_pkg::ST_FILL: begin
        if (can_load) state_d = last_fill ? fgf_pkg::ST_REAL : fgf_pkg::ST_START;
      end
      fgf_pkg::ST_REAL:  if (can_load) state_d = fgf_pkg::ST_IDLE;
      default:           state_d = fgf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_fill     = 1'b0;
    load_real     = 1'b0;
    case (state_q)
      fgf_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      fgf_pkg::ST_START: div_start = 1'b1;
      fgf_pkg::ST_FILL:  load_fill = can_load;
      fgf_pkg::ST_REAL:  load_real = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fgf_pkg::ST_IDLE;
      valid_q     <= 1'b0;
      exp_q       <= '0;
      lost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xact && s_axis_tuser) begin
        valid_q <= 1'b0;
        lost_q  <= '0;
      end
      if (load_fill) begin
        exp_q  <= exp_q + 1'b1;
        lost_q <= lost_inc;
      end
      if (load_real) begin
        exp_q   <= cur_seq_q + 1'b1;
        valid_q <= 1'b1;
      end
      if (load_fill || load_real) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      cur_seq_q   <= s_axis_tdata[OffAlo-1:0];
      cur_alo_q   <= s_axis_tdata[OffAhi-1:OffAlo];
      cur_ahi_q   <= s_axis_tdata[OffDig-1:OffAhi];
      cur_dig_q   <= s_axis_tdata[OffStm-1:OffDig];
      cur_stamp_q <= s_axis_tdata[InW-1:OffStm];
    end
    if (state_q == fgf_pkg::ST_CHECK) begin
      r_q <= seq_dist + 1'b1;
    end
    if (load_fill) begin
      r_q          <= r_q - 1'b1;
      prev_dig_q   <= fill_dig;
      prev_stamp_q <= fill_stamp;
      out_seq_q    <= exp_q;
      out_alo_q    <= prev_alo_q;
      out_ahi_q    <= prev_ahi_q;
      out_dig_q    <= fill_dig;
      out_stamp_q  <= fill_stamp;
      out_filled_q <= 1'b1;
      out_last_q   <= 1'b0;
      out_lost_q   <= lost_inc;
    end
    if (load_real) begin
      prev_alo_q   <= cur_alo_q;
      prev_ahi_q   <= cur_ahi_q;
      prev_dig_q   <= cur_dig_q;
      prev_stamp_q <= cur_stamp_q;
      out_seq_q    <= cur_seq_q;
      out_alo_q    <= cur_alo_q;
      out_ahi_q    <= cur_ahi_q;
      out_dig_q    <= cur_dig_q;
      out_stamp_q  <= cur_stamp_q;
      out_filled_q <= 1'b0;
      out_last_q   <= 1'b1;
      out_lost_q   <= lost_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTw'({out_lost_q, out_stamp_q, out_dig_q,
                                 out_ahi_q, out_alo_q, out_seq_q});
  assign m_axis_tuser  = out_filled_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* hw/rtl/fgf_div.sv */
// Restoring divider, one quotient bit per cycle.
module fgf_div #(
  parameter int unsigned SEQ_BITS = fgf_pkg::SeqBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fgf_pkg::StampBits-1:0] dividend_i,
  input  logic [SEQ_BITS-1:0]          divisor_i,
  output logic                         done_o,
  output logic [fgf_pkg::StampBits-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(fgf_pkg::StampBits);
  localparam logic [CntW-1:0] CntLast = CntW'(fgf_pkg::StampBits - 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [fgf_pkg::StampBits-1:0] quo_q, quo_d;
  logic [SEQ_BITS-1:0]           rem_q, rem_d;
  logic [SEQ_BITS-1:0]           dvs_q, dvs_d;
  logic [SEQ_BITS:0]             trial;
  logic [SEQ_BITS:0]             diff;
  logic                          ge;

  assign trial = {rem_q, quo_q[fgf_pkg::StampBits-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // dividend bits shift out the top, quotient bits shift in at the bottom
      quo_d = {quo_q[fgf_pkg::StampBits-2:0], ge};
      rem_d = ge ? diff[SEQ_BITS-1:0] : trial[SEQ_BITS-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* bench/frame_gap_filler_top_test.sv */
module frame_gap_filler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SeqW    = fgf_pkg::SeqBitsDef;
  localparam int unsigned AnaW    = 4 * fgf_pkg::SampleBitsDef;
  localparam int unsigned DigW    = fgf_pkg::DigBits;
  localparam int unsigned StampW  = fgf_pkg::StampBits;
  localparam int unsigned LostW   = fgf_pkg::LostBits;
  localparam int unsigned InW     = SeqW + 2 * AnaW + DigW + StampW;
  localparam int unsigned InTw    = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW    = InW + LostW;
  localparam int unsigned OutTw   = ((OutW + 7) / 8) * 8;
  localparam int unsigned DigLo   = SeqW + 2 * AnaW;
  localparam int unsigned StampLo = DigLo + DigW;
  localparam int unsigned LostLo  = StampLo + StampW;
  localparam int unsigned HalfSeq = 1 << (SeqW - 1);
  localparam int unsigned HoldOff = 500;

  typedef struct {
    logic [SeqW-1:0]   seq;
    logic [AnaW-1:0]   alo;
    logic [AnaW-1:0]   ahi;
    logic [DigW-1:0]   dig;
    logic [StampW-1:0] stamp;
    logic              restart;
  } frame_t;

  typedef struct {
    logic [SeqW-1:0]   seq;
    logic [AnaW-1:0]   alo;
    logic [AnaW-1:0]   ahi;
    logic [DigW-1:0]   dig;
    logic [StampW-1:0] stamp;
    logic [LostW-1:0]  lost;
    logic              filled;
    logic              last;
  } emitted_t;

  class gap_fill_scoreboard;
    logic [SeqW-1:0]   seq_expect;
    bit                seq_known;
    logic [AnaW-1:0]   held_alo;
    logic [AnaW-1:0]   held_ahi;
    logic [DigW-1:0]   held_dig;
    logic [StampW-1:0] held_stamp;
    logic [LostW-1:0]  lost_total;
    emitted_t          frames_due[$];
    int unsigned       errors;

    function new();
      seq_expect = '0;
      seq_known  = 1'b0;
      held_alo   = '0;
      held_ahi   = '0;
      held_dig   = '0;
      held_stamp = '0;
      lost_total = '0;
      errors     = 0;
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    function void queue_frame(input logic [SeqW-1:0] seq, input logic [DigW-1:0] dig,
                              input logic [StampW-1:0] stamp, input logic filled);
      emitted_t e;
      e.seq    = seq;
      e.alo    = held_alo;
      e.ahi    = held_ahi;
      e.dig    = dig;
      e.stamp  = stamp;
      e.lost   = lost_total;
      e.filled = filled;
      e.last   = !filled;
      frames_due.push_back(e);
    endfunction

    // works out the fillers and the real frame caused by one accepted frame
    function void note_frame(input frame_t f);
      logic [SeqW-1:0]   gap;
      logic [SeqW-1:0]   r_dist;
      logic [StampW-1:0] span;
      logic [StampW-1:0] interp;
      logic [DigW-1:0]   dig;
      if (f.restart) begin
        seq_known  = 1'b0;
        lost_total = '0;
      end
      if (seq_known) begin
        gap = f.seq - seq_expect;
        if (gap != 0 && gap < HalfSeq) begin
          while (seq_expect != f.seq) begin
            r_dist = f.seq - seq_expect + 1'b1;
            span   = f.stamp - held_stamp;
            interp = held_stamp + span / r_dist;
            dig    = (r_dist > 2) ? held_dig : f.dig;
            held_stamp = interp;
            held_dig   = dig;
            if (lost_total != '1)
              lost_total++;
            queue_frame(seq_expect, dig, interp, 1'b1);
            seq_expect++;
          end
        end
      end
      held_alo   = f.alo;
      held_ahi   = f.ahi;
      held_dig   = f.dig;
      held_stamp = f.stamp;
      queue_frame(f.seq, f.dig, f.stamp, 1'b0);
      seq_expect = f.seq + 1'b1;
      seq_known  = 1'b1;
    endfunction

    task check_frame(input emitted_t got);
      emitted_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("unexpected transaction, seq %0d", got.seq));
        return;
      end
      want = frames_due.pop_front();
      if (got.seq !== want.seq)
        report($sformatf("seq %0d, want %0d", got.seq, want.seq));
      if (got.alo !== want.alo)
        report($sformatf("seq %0d analog_low %h, want %h", want.seq, got.alo, want.alo));
      if (got.ahi !== want.ahi)
        report($sformatf("seq %0d analog_high %h, want %h", want.seq, got.ahi, want.ahi));
      if (got.dig !== want.dig)
        report($sformatf("seq %0d digital %h, want %h", want.seq, got.dig, want.dig));
      if (got.stamp !== want.stamp)
        report($sformatf("seq %0d stamp %0d, want %0d", want.seq, got.stamp, want.stamp));
      if (got.lost !== want.lost)
        report($sformatf("seq %0d lost %0d, want %0d", want.seq, got.lost, want.lost));
      if (got.filled !== want.filled)
        report($sformatf("seq %0d filled %b, want %b", want.seq, got.filled, want.filled));
      if (got.last !== want.last)
        report($sformatf("seq %0d last %b, want %b", want.seq, got.last, want.last));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [InTw-1:0]  s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OutTw-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;

  bit idle_on;
  bit hold_off;

  gap_fill_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  frame_gap_filler_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [AnaW-1:0] any_samples();
    return AnaW'({$urandom, $urandom});
  endfunction

  function automatic frame_t mk_frame(input logic [SeqW-1:0] seq, input logic [AnaW-1:0] alo,
                                      input logic [AnaW-1:0] ahi, input logic [DigW-1:0] dig,
                                      input logic [StampW-1:0] stamp, input logic restart);
    frame_t f;
    f.seq     = seq;
    f.alo     = alo;
    f.ahi     = ahi;
    f.dig     = dig;
    f.stamp   = stamp;
    f.restart = restart;
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    if (idle_on && !hold_off && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTw - InW){1'b0}}, f.stamp, f.dig, f.ahi, f.alo, f.seq};
    s_axis_tuser  <= f.restart;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_frame(f);
  endtask

  // downstream side: random stalls, plus one long hold-off on request
  initial begin : sink
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : watch
    emitted_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.seq    = m_axis_tdata[0 +: SeqW];
      got.alo    = m_axis_tdata[SeqW +: AnaW];
      got.ahi    = m_axis_tdata[SeqW + AnaW +: AnaW];
      got.dig    = m_axis_tdata[DigLo +: DigW];
      got.stamp  = m_axis_tdata[StampLo +: StampW];
      got.lost   = m_axis_tdata[LostLo +: LostW];
      got.filled = m_axis_tuser;
      got.last   = m_axis_tlast;
      sb.check_frame(got);
    end
  end

  initial begin : stim
    frame_t            f;
    int unsigned       pick;
    int unsigned       gap;
    logic [SeqW-1:0]   seq_next;
    logic [StampW-1:0] stamp_now;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    idle_on  = 1'b1;
    hold_off = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first frame after reset, then match across the sequence wrap
    send_frame(mk_frame(7'd127, '0, '0, 8'h00, 32'd0, 1'b0));
    send_frame(mk_frame(7'd0, '1, '1, 8'hFF, 32'hFFFF_FFFF, 1'b0));
    // one missing, stamp wraps; two missing, digital held on the first filler
    send_frame(mk_frame(7'd2, any_samples(), any_samples(), 8'h5A, 32'd100, 1'b0));
    send_frame(mk_frame(7'd5, any_samples(), any_samples(), 8'hA5, 32'd1000, 1'b0));
    send_frame(mk_frame(7'd6, any_samples(), any_samples(), 8'h3C, 32'd1000, 1'b0));
    // forward jump past half the space: resync
    send_frame(mk_frame(7'd100, any_samples(), any_samples(), 8'h81, 32'd2000, 1'b0));
    send_frame(mk_frame(7'd101, any_samples(), any_samples(), 8'h18, 32'd2100, 1'b0));
    // largest gap, 63 fillers across the wrap
    send_frame(mk_frame(7'd37, any_samples(), any_samples(), 8'hC3, 32'd8400, 1'b0));
    send_frame(mk_frame(7'd38, any_samples(), any_samples(), 8'h24, 32'd8500, 1'b0));
    // exactly half the space, then a step backwards: both resync
    send_frame(mk_frame(7'd103, any_samples(), any_samples(), 8'h42, 32'd8600, 1'b0));
    send_frame(mk_frame(7'd102, any_samples(), any_samples(), 8'h99, 32'd8700, 1'b0));
    send_frame(mk_frame(7'd125, any_samples(), any_samples(), 8'h66, 32'd9000, 1'b0));
    // fillers wrap through zero while the stamp goes backwards
    send_frame(mk_frame(7'd3, any_samples(), any_samples(), 8'h0F, 32'd500, 1'b0));
    // restart drops validity and the lost count, gap or not
    send_frame(mk_frame(7'd40, any_samples(), any_samples(), 8'hF0, 32'd600, 1'b1));
    send_frame(mk_frame(7'd41, any_samples(), any_samples(), 8'h11, 32'd700, 1'b0));
    send_frame(mk_frame(7'd45, any_samples(), any_samples(), 8'h22, 32'd800, 1'b1));
    send_frame(mk_frame(7'd47, any_samples(), any_samples(), 8'h33, 32'd900, 1'b0));
    send_frame(mk_frame(7'd48, any_samples(), any_samples(), 8'h44, 32'd950, 1'b1));
    // stamp step smaller than the distance: interpolation truncates to zero
    send_frame(mk_frame(7'd53, any_samples(), any_samples(), 8'h55, 32'd953, 1'b0));

    seq_next  = 7'd54;
    stamp_now = 32'd953;
    for (int i = 0; i < 400; i++) begin
      if (i == 30)
        hold_off = 1'b1;
      if (i == 340)
        idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 70)
        gap = 0;
      else if (pick < 88)
        gap = $urandom_range(1, 4);
      else if (pick < 94)
        gap = $urandom_range(5, HalfSeq - 1);
      else
        gap = $urandom_range(HalfSeq, 2 * HalfSeq - 1);
      f.seq     = seq_next + SeqW'(gap);
      f.alo     = any_samples();
      f.ahi     = any_samples();
      f.dig     = DigW'($urandom);
      f.restart = ($urandom_range(0, 49) == 0);
      if ($urandom_range(0, 9) == 0)
        f.stamp = $urandom;
      else
        f.stamp = stamp_now + StampW'($urandom_range(1, 4000) * (gap + 1));
      // occasional noise: a frame out of nowhere
      if ($urandom_range(0, 29) == 0)
        f.seq = SeqW'($urandom);
      send_frame(f);
      seq_next  = f.seq + 1'b1;
      stamp_now = f.stamp;
    end
    s_axis_tvalid <= 1'b0;

    while (sb.frames_due.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : limit
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
